### hw/rtl/itp_pkg.sv
// Shared types, character codes and operator tables for the infix to postfix converter.
// Used by itp_front, itp_fifo, itp_back and the top level; depends on nothing.

package itp_pkg;

  // Default operator stack depth handed to the top level
  localparam int unsigned STACK_DEPTH_DEF = 32;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // ASCII codes the converter understands
  localparam logic [7:0] CH_OPEN     = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE    = 8'h29;  // ')'
  localparam logic [7:0] CH_STAR     = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS    = 8'h2D;  // '-'
  localparam logic [7:0] CH_SLASH    = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET    = 8'h5E;  // '^'
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_LO = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LOWER_LO = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;  // 'z'

  // Stack entry codes
  localparam int unsigned OPC_W = 3;
  localparam logic [OPC_W-1:0] OPC_OPEN  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_PLUS  = 3'd1;
  localparam logic [OPC_W-1:0] OPC_MINUS = 3'd2;
  localparam logic [OPC_W-1:0] OPC_STAR  = 3'd3;
  localparam logic [OPC_W-1:0] OPC_SLASH = 3'd4;
  localparam logic [OPC_W-1:0] OPC_CARET = 3'd5;

  // Error codes carried on every result beat of a character
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // Character classes found by the front end
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LIT   = 3'd1,
    CMD_OPEN  = 3'd2,
    CMD_CLOSE = 3'd3,
    CMD_OP    = 3'd4
  } cmd_kind_e;

  // One classified character, as queued from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [OPC_W-1:0] code;
    logic [7:0]       ch;
    logic             last;
  } cmd_t;

  // Character printed for a stack entry
  function automatic logic [7:0] code_char(input logic [OPC_W-1:0] code);
    logic [7:0] c;
    case (code)
      OPC_OPEN:  c = CH_OPEN;
      OPC_PLUS:  c = CH_PLUS;
      OPC_MINUS: c = CH_MINUS;
      OPC_STAR:  c = CH_STAR;
      OPC_SLASH: c = CH_SLASH;
      OPC_CARET: c = CH_CARET;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // Precedence of a stack entry
  function automatic logic [1:0] code_prec(input logic [OPC_W-1:0] code);
    logic [1:0] p;
    case (code)
      OPC_PLUS, OPC_MINUS:  p = 2'd1;
      OPC_STAR, OPC_SLASH:  p = 2'd2;
      OPC_CARET:            p = 2'd3;
      default:              p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/itp_front.sv
// Front end: accepts input characters and classifies them into commands.
// Depends on itp_pkg; feeds the command queue itp_fifo.

module itp_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_expr_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output itp_pkg::cmd_t     cmd_o
);

  // Pass the handshake straight to the queue
  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  // Classify the character
  always_comb begin
    cmd_o.kind = itp_pkg::CMD_NONE;
    cmd_o.code = itp_pkg::OPC_OPEN;
    cmd_o.ch   = in_char_i;
    cmd_o.last = end_of_expr_i;
    unique case (in_char_i) inside
      [itp_pkg::CH_DIGIT_LO:itp_pkg::CH_DIGIT_HI],
      [itp_pkg::CH_UPPER_LO:itp_pkg::CH_UPPER_HI],
      [itp_pkg::CH_LOWER_LO:itp_pkg::CH_LOWER_HI]: begin
        cmd_o.kind = itp_pkg::CMD_LIT;
      end
      itp_pkg::CH_OPEN: begin
        cmd_o.kind = itp_pkg::CMD_OPEN;
      end
      itp_pkg::CH_CLOSE: begin
        cmd_o.kind = itp_pkg::CMD_CLOSE;
      end
      itp_pkg::CH_PLUS: begin
        cmd_o.kind = itp_pkg::CMD_OP;
        cmd_o.code = itp_pkg::OPC_PLUS;
      end
      itp_pkg::CH_MINUS: begin
        cmd_o.kind = itp_pkg::CMD_OP;
        cmd_o.code = itp_pkg::OPC_MINUS;
      end
      itp_pkg::CH_STAR: begin
        cmd_o.kind = itp_pkg::CMD_OP;
        cmd_o.code = itp_pkg::OPC_STAR;
      end
      itp_pkg::CH_SLASH: begin
        cmd_o.kind = itp_pkg::CMD_OP;
        cmd_o.code = itp_pkg::OPC_SLASH;
      end
      itp_pkg::CH_CARET: begin
        cmd_o.kind = itp_pkg::CMD_OP;
        cmd_o.code = itp_pkg::OPC_CARET;
      end
      default: begin
        cmd_o.kind = itp_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

### hw/rtl/itp_fifo.sv
// Short command queue between the front end and the stack engine.
// Depends on itp_pkg for the command type and the queue depth.

module itp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  itp_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output itp_pkg::cmd_t rd_data_o
);

  localparam int unsigned PtrW = (itp_pkg::QUEUE_DEPTH > 1) ? $clog2(itp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(itp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(itp_pkg::QUEUE_DEPTH - 1);

  itp_pkg::cmd_t   entry_q [itp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(itp_pkg::QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the payload of each slot
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/itp_back.sv
// Back end: runs queued commands against the operator stack and drives result beats.
// Depends on itp_pkg; holds the stack memory and the output register.

module itp_back #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  itp_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          char_valid_o,
  output logic          out_last_o,
  output logic [1:0]    error_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam logic [CntW-1:0] Full = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] One  = CntW'(1);
  localparam logic [CntW-1:0] Two  = CntW'(2);

  typedef enum logic [2:0] {
    ST_MAIN  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_MARK  = 3'b100
  } back_state_e;

  back_state_e              state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          paren_q, paren_d;
  logic [1:0]               err_q, err_d;
  logic                     emitted_q, emitted_d;
  logic [itp_pkg::OPC_W-1:0] mem_q [STACK_DEPTH];
  logic [itp_pkg::OPC_W-1:0] rd_data_q;
  logic [itp_pkg::OPC_W-1:0] top;
  logic [CntW-1:0]          rd_cnt;
  logic [IdxW-1:0]          rd_addr, wr_addr;
  logic                     push;
  logic [itp_pkg::OPC_W-1:0] push_code;
  logic                     out_free, stack_nz, stack_full, top_is_op;
  logic                     emit, e_valid, e_last;
  logic [7:0]               e_char;
  logic [1:0]               e_err;
  logic                     finish, fin_em;
  logic [1:0]               fin_err;
  logic                     out_valid_q;
  logic [7:0]               out_char_q;
  logic                     char_valid_q, out_last_q;
  logic [1:0]               error_q;

  // The read register always mirrors the entry under the stack pointer
  assign top        = rd_data_q;
  assign stack_nz   = (count_q != '0);
  assign stack_full = (count_q == Full);
  assign top_is_op  = stack_nz && (top != itp_pkg::OPC_OPEN);
  assign out_free   = !out_valid_q || out_ready_i;

  // Step through the current command
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    paren_d   = paren_q;
    err_d     = err_q;
    emitted_d = emitted_q;
    push      = 1'b0;
    push_code = itp_pkg::OPC_OPEN;
    emit      = 1'b0;
    e_char    = 8'h00;
    e_valid   = 1'b1;
    e_last    = 1'b0;
    e_err     = itp_pkg::ERR_NONE;
    cmd_ready_o = 1'b0;
    finish    = 1'b0;
    fin_err   = itp_pkg::ERR_NONE;

    unique case (state_q)
      ST_MAIN: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            itp_pkg::CMD_LIT: begin
              if (out_free) begin
                emit   = 1'b1;
                e_char = cmd_i.ch;
                e_last = cmd_i.last && !stack_nz;
                finish = 1'b1;
              end
            end
            itp_pkg::CMD_OPEN: begin
              if (stack_full) begin
                fin_err = itp_pkg::ERR_OVERFLOW;
              end else begin
                push    = 1'b1;
                count_d = count_q + One;
                paren_d = paren_q + One;
              end
              finish = 1'b1;
            end
            itp_pkg::CMD_CLOSE: begin
              if (top_is_op) begin
                if (out_free) begin
                  emit    = 1'b1;
                  e_char  = itp_pkg::code_char(top);
                  // Final beat when nothing, or only the lone open bracket, lies beneath
                  e_last  = cmd_i.last &&
                            ((count_q == One) || ((count_q == Two) && (paren_q == One)));
                  e_err   = (paren_q == '0) ? itp_pkg::ERR_UNMATCHED : itp_pkg::ERR_NONE;
                  count_d = count_q - One;
                end
              end else if (stack_nz) begin
                // Drop the matching open parenthesis
                count_d = count_q - One;
                paren_d = paren_q - One;
                finish  = 1'b1;
              end else begin
                fin_err = itp_pkg::ERR_UNMATCHED;
                finish  = 1'b1;
              end
            end
            itp_pkg::CMD_OP: begin
              if (top_is_op &&
                  (itp_pkg::code_prec(top) >= itp_pkg::code_prec(cmd_i.code))) begin
                if (out_free) begin
                  emit    = 1'b1;
                  e_char  = itp_pkg::code_char(top);
                  count_d = count_q - One;
                end
              end else begin
                if (stack_full) begin
                  fin_err = itp_pkg::ERR_OVERFLOW;
                end else begin
                  push      = 1'b1;
                  push_code = cmd_i.code;
                  count_d   = count_q + One;
                end
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
          if (emit) begin
            emitted_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit    = 1'b1;
          e_char  = itp_pkg::code_char(top);
          e_last  = (count_q == One);
          e_err   = err_q;
          count_d = count_q - One;
          if (top == itp_pkg::OPC_OPEN) begin
            paren_d = paren_q - One;
          end
          if (count_q == One) begin
            cmd_ready_o = 1'b1;
            emitted_d   = 1'b0;
            paren_d     = '0;
            state_d     = ST_MAIN;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          emit        = 1'b1;
          e_valid     = 1'b0;
          e_last      = cmd_i.last;
          e_err       = err_q;
          cmd_ready_o = 1'b1;
          emitted_d   = 1'b0;
          state_d     = ST_MAIN;
        end
      end
      default: begin
        state_d = ST_MAIN;
      end
    endcase

    // Close the character: flush, send a bare marker, or retire it
    fin_em = emitted_q || emit;
    if (finish) begin
      if (cmd_i.last && (count_d != '0)) begin
        err_d   = fin_err;
        state_d = ST_FLUSH;
      end else if ((cmd_i.last || (fin_err != itp_pkg::ERR_NONE)) && !fin_em) begin
        err_d   = fin_err;
        state_d = ST_MARK;
      end else begin
        cmd_ready_o = 1'b1;
        emitted_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_MAIN;
      count_q   <= '0;
      paren_q   <= '0;
      err_q     <= itp_pkg::ERR_NONE;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      paren_q   <= paren_d;
      err_q     <= err_d;
      emitted_q <= emitted_d;
    end
  end

  // Stack memory with a registered read of the next top, bypassing a same-cycle push
  assign rd_cnt  = count_d - One;
  assign rd_addr = rd_cnt[IdxW-1:0];
  assign wr_addr = count_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_addr] <= push_code;
    end
    if (push && (wr_addr == rd_addr)) begin
      rd_data_q <= push_code;
    end else begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Output register: hold a beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q   <= e_char;
      char_valid_q <= e_valid;
      out_last_q   <= e_last;
      error_q      <= e_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = char_valid_q;
  assign out_last_o   = out_last_q;
  assign error_o      = error_q;

  // Stack pointer never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("stack pointer beyond depth");

  // Open parentheses on the stack never outnumber its entries
  a_paren_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paren_q <= count_q)
    else $error("parenthesis count exceeds stack pointer");

  // A flush only runs on a non-empty stack
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> stack_nz)
    else $error("flush on empty stack");

  // A bare marker is only sent for a character that sent nothing else
  a_mark_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> !emitted_q)
    else $error("bare marker after emitted beats");

  // Push never lands on a full stack
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stack_full)
    else $error("push on full stack");

endmodule

### hw/rtl/infix_to_postfix_converter_core.sv
// Top level of the infix to postfix converter (shunting-yard, one character a beat).
// Depends on itp_pkg, itp_front, itp_fifo and itp_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | in_char_i, end_of_expr_i
//  out     | source    | out_valid_o/out_ready_i | out_char_o, char_valid_o, out_last_o, error_o
//
// In the stack engine a literal gives one result beat and so does each operator a character pops;
// one that emits nothing but ends an expression or raises an error sends a bare marker, and
// the last character of an expression also flushes every entry left on the stack.
// One stack pop per cycle while the output is not stalled, limited by the single stack
// memory read port, sets the rate. The first result beat of a character passes through
// the queue and then the output register.
// Reset (rst_ni low, asynchronous) empties the stack, the queue and the output register.
// A stalled output holds the engine; the two-entry queue keeps taking input until it fills.

module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       out_last_o,
  output logic [1:0] error_o
);

  logic          fr_valid, fr_ready;
  itp_pkg::cmd_t fr_cmd;
  logic          bk_valid, bk_ready;
  itp_pkg::cmd_t bk_cmd;

  // Classify incoming characters
  itp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready),
    .cmd_o         (fr_cmd)
  );

  // Decouple front and back
  itp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_cmd)
  );

  // Run the stack and drive result beats
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (bk_valid),
    .cmd_ready_o  (bk_ready),
    .cmd_i        (bk_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .out_last_o   (out_last_o),
    .error_o      (error_o)
  );

endmodule

### dv/infix_to_postfix_converter_core_test.sv
// Self-checking testbench for infix_to_postfix_converter_core: a directed table, a long
// output stall, a stack overfill and random expressions, checked beat by beat.
// Depends on itp_pkg and the converter RTL only.

`timescale 1ns / 100ps

module infix_to_postfix_converter_core_test;

  localparam int unsigned DEPTH          = itp_pkg::STACK_DEPTH_DEF;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1500;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned DIR_ROWS       = 26;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic [1:0] err;
  } postfix_beat_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0]    ch;
    logic          eoe;
    logic          typed;
    postfix_beat_t want;
  } stim_row_t;

  localparam postfix_beat_t NO_BEAT = '0;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i     = 8'h00;
  logic       end_of_expr_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic       out_last_o;
  logic [1:0] error_o;

  // Predictor state: open brackets and operators held as characters
  logic [7:0]    op_stack [DEPTH];
  int unsigned   op_depth = 0;
  postfix_beat_t step_beats [$];
  postfix_beat_t beats_due [$];
  postfix_beat_t due_beat;
  logic [7:0]    expr_q [$];

  int unsigned live_items    = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  bit          idling_on     = 1'b1;
  bit          hold_off_req  = 1'b0;

  // Directed rows: extremes after reset, every operator, and the unmatched-bracket errors
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{"A",   1'b0, 1'b1, '{"A",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    // close bracket on an empty stack gives a bare error beat
    '{")",   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, itp_pkg::ERR_UNMATCHED}},
    '{"Z",   1'b0, 1'b1, '{"Z",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    '{"a",   1'b0, 1'b1, '{"a",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    '{"z",   1'b0, 1'b1, '{"z",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    '{"0",   1'b0, 1'b1, '{"0",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    '{"9",   1'b0, 1'b1, '{"9",   1'b1, 1'b0, itp_pkg::ERR_NONE}},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    // ignored final character on an empty stack gives the bare end marker
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, itp_pkg::ERR_NONE}},
    '{"a",   1'b0, 1'b0, NO_BEAT},
    '{"+",   1'b0, 1'b0, NO_BEAT},
    '{"b",   1'b0, 1'b0, NO_BEAT},
    '{"*",   1'b0, 1'b0, NO_BEAT},
    '{"(",   1'b0, 1'b0, NO_BEAT},
    '{"c",   1'b0, 1'b0, NO_BEAT},
    '{"-",   1'b0, 1'b0, NO_BEAT},
    '{"d",   1'b0, 1'b0, NO_BEAT},
    '{")",   1'b0, 1'b0, NO_BEAT},
    '{"^",   1'b0, 1'b0, NO_BEAT},
    '{"e",   1'b0, 1'b0, NO_BEAT},
    '{"/",   1'b0, 1'b0, NO_BEAT},
    '{"f",   1'b1, 1'b0, NO_BEAT},
    // unmatched open bracket is flushed as a character
    '{"(",   1'b1, 1'b1, '{"(",   1'b1, 1'b1, itp_pkg::ERR_NONE}},
    '{"+",   1'b0, 1'b0, NO_BEAT},
    // close bracket pops the operator, then finds no open bracket
    '{")",   1'b0, 1'b0, NO_BEAT},
    '{")",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, itp_pkg::ERR_UNMATCHED}}
  };

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .end_of_expr_i(end_of_expr_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .out_last_o   (out_last_o),
    .error_o      (error_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Character classes and operator ranks
  function automatic bit is_operand(input logic [7:0] c);
    return (c >= itp_pkg::CH_DIGIT_LO && c <= itp_pkg::CH_DIGIT_HI) ||
           (c >= itp_pkg::CH_UPPER_LO && c <= itp_pkg::CH_UPPER_HI) ||
           (c >= itp_pkg::CH_LOWER_LO && c <= itp_pkg::CH_LOWER_HI);
  endfunction

  function automatic int unsigned op_rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return 2;
      itp_pkg::CH_CARET:                   return 3;
      default:                             return 0;
    endcase
  endfunction

  // Advance the shunting-yard state by one character and fill step_beats
  function automatic void shunt_char(input logic [7:0] c, input logic eoe);
    logic [7:0] emitted [$];
    logic [1:0] err;
    err = itp_pkg::ERR_NONE;
    step_beats.delete();
    if (is_operand(c)) begin
      emitted.push_back(c);
    end else if (c == itp_pkg::CH_OPEN) begin
      if (op_depth < DEPTH) begin
        op_stack[op_depth] = c;
        op_depth++;
      end else begin
        err = itp_pkg::ERR_OVERFLOW;
      end
    end else if (c == itp_pkg::CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN) begin
        emitted.push_back(op_stack[op_depth-1]);
        op_depth--;
      end
      if (op_depth > 0) op_depth--;
      else err = itp_pkg::ERR_UNMATCHED;
    end else if (op_rank(c) != 0) begin
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN &&
             op_rank(op_stack[op_depth-1]) >= op_rank(c)) begin
        emitted.push_back(op_stack[op_depth-1]);
        op_depth--;
      end
      if (op_depth < DEPTH) begin
        op_stack[op_depth] = c;
        op_depth++;
      end else begin
        err = itp_pkg::ERR_OVERFLOW;
      end
    end
    // Flush everything, open brackets included, on the final character
    if (eoe) begin
      while (op_depth > 0) begin
        emitted.push_back(op_stack[op_depth-1]);
        op_depth--;
      end
    end
    if (emitted.size() == 0) begin
      if (eoe || err != itp_pkg::ERR_NONE) step_beats.push_back('{8'h00, 1'b0, eoe, err});
    end else begin
      foreach (emitted[k])
        step_beats.push_back('{emitted[k], 1'b1, eoe && (k == emitted.size() - 1), err});
    end
  endfunction

  // Random content
  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(itp_pkg::CH_DIGIT_LO + $urandom_range(0, 9));
      1:       return 8'(itp_pkg::CH_UPPER_LO + $urandom_range(0, 25));
      default: return 8'(itp_pkg::CH_LOWER_LO + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255));
  endfunction

  // Well-formed expression grammar, appended to expr_q
  function automatic void gen_term(input int unsigned lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      expr_q.push_back(itp_pkg::CH_OPEN);
      gen_expr(lvl + 1);
      expr_q.push_back(itp_pkg::CH_CLOSE);
    end else begin
      expr_q.push_back(rand_operand());
    end
  endfunction

  function automatic void gen_expr(input int unsigned lvl);
    int unsigned n_ops;
    n_ops = $urandom_range(0, 3);
    gen_term(lvl);
    repeat (n_ops) begin
      expr_q.push_back(rand_op());
      gen_term(lvl);
    end
  endfunction

  // Deep nesting around the stack limit; mixed adds operand/operator pairs and closing brackets
  function automatic void gen_deep(input int unsigned n_open, input bit mixed);
    repeat (n_open) begin
      expr_q.push_back(itp_pkg::CH_OPEN);
      if (mixed && $urandom_range(0, 1)) begin
        expr_q.push_back(rand_operand());
        expr_q.push_back(rand_op());
      end
    end
    expr_q.push_back(rand_operand());
    if (mixed) repeat ($urandom_range(0, n_open)) expr_q.push_back(itp_pkg::CH_CLOSE);
  endfunction

  // Offer one character, hold it until accepted, then record its result beats
  task automatic offer_char(input logic [7:0] c, input logic eoe, input logic typed,
                            input postfix_beat_t want);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    in_char_i     <= c;
    end_of_expr_i <= eoe;
    do @(posedge clk_i); while (!in_ready_o);
    shunt_char(c, eoe);
    if (typed) beats_due.push_back(want);
    else foreach (step_beats[k]) beats_due.push_back(step_beats[k]);
    if (eoe || is_operand(c) || op_rank(c) != 0 || c == itp_pkg::CH_OPEN ||
        c == itp_pkg::CH_CLOSE)
      live_items++;
  endtask

  // Send expr_q as one expression, the final character flagged
  task automatic send_expr(input bit noisy);
    for (int unsigned i = 0; i < expr_q.size(); i++) begin
      if (noisy && $urandom_range(0, 11) == 0) offer_char(pick_noise(), 1'b0, 1'b0, NO_BEAT);
      offer_char(expr_q[i], i == expr_q.size() - 1, 1'b0, NO_BEAT);
    end
  endtask

  // Mostly well-formed expressions, with broken ones, noise and deep nesting mixed in
  task automatic run_random(input int unsigned target, input bit keep_idle);
    int unsigned goal;
    int unsigned kind;
    int unsigned pos;
    goal = live_items + target;
    while (live_items < goal) begin
      kind = $urandom_range(0, 99);
      expr_q.delete();
      if (kind < 6) begin
        gen_deep($urandom_range(DEPTH - 3, DEPTH + 3), 1'b1);
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 6)) expr_q.push_back(pick_noise());
      end else begin
        gen_expr(0);
        // break the expression: drop a character or add a stray bracket
        if (kind < 30) begin
          pos = $urandom_range(0, expr_q.size() - 1);
          case ($urandom_range(0, 2))
            0:       if (expr_q.size() > 1) expr_q.delete(pos);
            1:       expr_q.insert(pos, itp_pkg::CH_OPEN);
            default: expr_q.insert(pos, itp_pkg::CH_CLOSE);
          endcase
        end
      end
      idling_on = keep_idle && ($urandom_range(0, 5) != 0);
      send_expr(kind >= 16 && $urandom_range(0, 2) == 0);
    end
  endtask

  // Output side: random stall bursts, and one long hold on request
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare every output beat with the oldest expected beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $error("unexpected result beat: out_char %h char_valid %b", out_char_o, char_valid_o);
        mismatches++;
      end else begin
        due_beat = beats_due.pop_front();
        if (out_char_o !== due_beat.ch) begin
          $error("out_char: expected %h, got %h", due_beat.ch, out_char_o);
          mismatches++;
        end
        if (char_valid_o !== due_beat.has_char) begin
          $error("char_valid: expected %b, got %b", due_beat.has_char, char_valid_o);
          mismatches++;
        end
        if (out_last_o !== due_beat.last) begin
          $error("out_last: expected %b, got %b", due_beat.last, out_last_o);
          mismatches++;
        end
        if (error_o !== due_beat.err) begin
          $error("error: expected %0d, got %0d", due_beat.err, error_o);
          mismatches++;
        end
      end
    end
  end

  // End the run if no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[r])
      offer_char(dir_rows[r].ch, dir_rows[r].eoe, dir_rows[r].typed, dir_rows[r].want);

    // Hold off the output while literals keep coming, so the input stalls
    hold_off_req = 1'b1;
    for (int unsigned i = 0; i < 24; i++)
      offer_char(rand_operand(), i == 23, 1'b0, NO_BEAT);

    // Pause until everything has drained, then push one bracket past the stack depth
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    expr_q.delete();
    gen_deep(DEPTH + 1, 1'b0);
    send_expr(1'b0);

    run_random(280, 1'b1);

    // Last stretch at full rate on both sides
    idling_on = 1'b0;
    run_random(70, 1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
